// ===== hw/rtl/tcq_pkg.sv =====
`default_nettype none

package tcq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int ID_BITS     = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int PTR_MOD     = 2 * QUEUE_DEPTH;
   localparam int PTR_W       = $clog2(PTR_MOD);
   localparam int ADDR_W      = IDX_W + 1;
   localparam int MEM_DEPTH   = 2 ** ADDR_W;
   localparam int FIELD_W     = 16;
   localparam int COUNT_W     = 8;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [PTR_W:0]     occ_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [ID_BITS-1:0] id_type;

   typedef enum logic [1:0] {
      OP_ARRIVE = 2'd0,
      OP_CALL   = 2'd1,
      OP_CANCEL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic               queue_class;
      logic [FIELD_W-1:0] customer_id;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] called_id;
      logic [FIELD_W-1:0] ticket;
      logic [COUNT_W-1:0] waiting_count;
   } rsp_type;

   typedef struct packed {
      logic   cancelled;
      id_type id;
   } entry_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type data;
   } mem_wr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } mem_rd_type;

   function automatic ptr_type ptr_next(ptr_type p);
      return (p == ptr_type'(PTR_MOD - 1)) ? '0 : p + ptr_type'(1);
   endfunction

   function automatic idx_type ptr_index(ptr_type p);
      return (p >= ptr_type'(QUEUE_DEPTH)) ? idx_type'(p - ptr_type'(QUEUE_DEPTH))
                                            : idx_type'(p);
   endfunction

   function automatic occ_type occupancy(ptr_type h, ptr_type t);
      occ_type wrap;
      wrap = (t >= h) ? '0 : occ_type'(PTR_MOD);
      return {1'b0, t} + wrap - {1'b0, h};
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcq_store.sv =====
`default_nettype none

module tcq_store (
   input  wire logic                clock,
   input  wire tcq_pkg::mem_wr_type wr,
   input  wire tcq_pkg::mem_rd_type rd,
   output tcq_pkg::entry_type       rd_data
);

   tcq_pkg::entry_type mem [tcq_pkg::MEM_DEPTH];
   tcq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/two_class_cancellable_ticket_queue_core.sv =====
// Channel   Ports                      Handshake
// request   start, busy, req_item      taken when start is high and busy is low
// response  rsp_valid, rsp_item        shown for one cycle, always taken
//
// An arrive is captured in the request register on acceptance, handled in the dispatch
// state, and its result is registered before it is shown. Call and cancel walk their
// class from the head, one entry per cycle through the single read port of the entry
// memory, and stop at the first match or at the tail.
// Reset clears pointers, ticket counters and the waiting count; memory is not cleared.
// The block never waits on the receiver of results.
`default_nettype none

module two_class_cancellable_ticket_queue_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tcq_pkg::req_type req_item,
   output logic                  rsp_valid,
   output tcq_pkg::rsp_type      rsp_item
);

   tcq_pkg::state_type state_ff, state_in;
   tcq_pkg::req_type   req_ff, req_in;
   tcq_pkg::ptr_type   walk_ff, walk_in;
   tcq_pkg::ptr_type   head_ff [2];
   tcq_pkg::ptr_type   head_in [2];
   tcq_pkg::ptr_type   tail_ff [2];
   tcq_pkg::ptr_type   tail_in [2];
   logic [tcq_pkg::FIELD_W-1:0] tickets_ff [2];
   logic [tcq_pkg::FIELD_W-1:0] tickets_in [2];
   logic [tcq_pkg::COUNT_W-1:0] count_ff, count_in;
   tcq_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   tcq_pkg::mem_wr_type mem_wr;
   tcq_pkg::mem_rd_type mem_rd;
   tcq_pkg::entry_type  rd_entry;

   logic             cls;
   tcq_pkg::op_type  op;
   tcq_pkg::ptr_type head_cur, tail_cur, walk_nxt;
   logic             is_full, is_scan_op, walk_at_tail, next_at_tail, hit;

   tcq_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (rd_entry)
   );

   assign cls          = req_ff.queue_class;
   assign op           = tcq_pkg::op_type'(req_ff.operation);
   assign head_cur     = head_ff[cls];
   assign tail_cur     = tail_ff[cls];
   assign walk_nxt     = tcq_pkg::ptr_next(walk_ff);
   assign is_full      = tcq_pkg::occupancy(head_cur, tail_cur)
                         >= tcq_pkg::occ_type'(tcq_pkg::QUEUE_DEPTH);
   assign is_scan_op   = (op == tcq_pkg::OP_CALL) || (op == tcq_pkg::OP_CANCEL);
   assign walk_at_tail = (walk_ff == tail_cur);
   assign next_at_tail = (walk_nxt == tail_cur);
   assign hit          = !rd_entry.cancelled && ((op == tcq_pkg::OP_CALL) ||
                         (rd_entry.id == req_ff.customer_id[tcq_pkg::ID_BITS-1:0]));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcq_pkg::S_IDLE: begin
            if (start) begin
               state_in = tcq_pkg::S_DISPATCH;
            end
         end
         tcq_pkg::S_DISPATCH: begin
            if (is_scan_op && !walk_at_tail) begin
               state_in = tcq_pkg::S_SCAN;
            end else begin
               state_in = tcq_pkg::S_IDLE;
            end
         end
         tcq_pkg::S_SCAN: begin
            if (hit || next_at_tail) begin
               state_in = tcq_pkg::S_IDLE;
            end
         end
         default: state_in = tcq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      walk_in      = walk_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      tickets_in   = tickets_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status        = tcq_pkg::ST_MISS;
      rsp_in.waiting_count = count_ff;
      mem_wr       = '0;
      mem_rd       = '0;
      unique case (state_ff)
         tcq_pkg::S_IDLE: begin
            if (start) begin
               req_in  = req_item;
               walk_in = head_ff[req_item.queue_class];
            end
         end
         tcq_pkg::S_DISPATCH: begin
            unique case (op)
               tcq_pkg::OP_ARRIVE: begin
                  rsp_valid_in = 1'b1;
                  if (is_full) begin
                     rsp_in.status = tcq_pkg::ST_FULL;
                  end else begin
                     mem_wr.en             = 1'b1;
                     mem_wr.addr           = {cls, tcq_pkg::ptr_index(tail_cur)};
                     mem_wr.data.cancelled = 1'b0;
                     mem_wr.data.id        = req_ff.customer_id[tcq_pkg::ID_BITS-1:0];
                     tail_in[cls]          = tcq_pkg::ptr_next(tail_cur);
                     tickets_in[cls]       = tickets_ff[cls] + tcq_pkg::FIELD_W'(1);
                     count_in              = count_ff + tcq_pkg::COUNT_W'(1);
                     rsp_in.status         = tcq_pkg::ST_OK;
                     rsp_in.ticket         = tickets_ff[cls];
                     rsp_in.waiting_count  = count_ff + tcq_pkg::COUNT_W'(1);
                  end
               end
               tcq_pkg::OP_CALL, tcq_pkg::OP_CANCEL: begin
                  if (walk_at_tail) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     mem_rd.en   = 1'b1;
                     mem_rd.addr = {cls, tcq_pkg::ptr_index(walk_ff)};
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         tcq_pkg::S_SCAN: begin
            if (op == tcq_pkg::OP_CALL) begin
               head_in[cls] = walk_nxt;
            end
            if (hit) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = tcq_pkg::ST_OK;
               count_in             = count_ff - tcq_pkg::COUNT_W'(1);
               rsp_in.waiting_count = count_ff - tcq_pkg::COUNT_W'(1);
               if (op == tcq_pkg::OP_CALL) begin
                  rsp_in.called_id = tcq_pkg::FIELD_W'(rd_entry.id);
               end else begin
                  mem_wr.en             = 1'b1;
                  mem_wr.addr           = {cls, tcq_pkg::ptr_index(walk_ff)};
                  mem_wr.data.cancelled = 1'b1;
                  mem_wr.data.id        = rd_entry.id;
               end
            end else begin
               walk_in = walk_nxt;
               if (next_at_tail) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  mem_rd.en   = 1'b1;
                  mem_rd.addr = {cls, tcq_pkg::ptr_index(walk_nxt)};
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcq_pkg::S_IDLE;
         head_ff      <= '{default: '0};
         tail_ff      <= '{default: '0};
         tickets_ff   <= '{default: '0};
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         tickets_ff   <= tickets_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      walk_ff <= walk_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != tcq_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Two results in consecutive cycles.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("Accepted item did not make the block busy.");

   a_fast_bound: assert property (@(posedge clock) disable iff (reset)
      tcq_pkg::occupancy(head_ff[0], tail_ff[0])
         <= tcq_pkg::occ_type'(tcq_pkg::QUEUE_DEPTH))
      else $error("Fast queue occupancy beyond depth.");

   a_slow_bound: assert property (@(posedge clock) disable iff (reset)
      tcq_pkg::occupancy(head_ff[1], tail_ff[1])
         <= tcq_pkg::occ_type'(tcq_pkg::QUEUE_DEPTH))
      else $error("Slow queue occupancy beyond depth.");

   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != tcq_pkg::ST_OK))
         |-> ((rsp_item.called_id == '0) && (rsp_item.ticket == '0)))
      else $error("Failed item carries a nonzero id or ticket.");

endmodule

`default_nettype wire

// ===== sim/ticket_queue_checker.sv =====
`timescale 1ns / 100ps

module ticket_queue_checker
   import tcq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_item,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_item,
   output int           mismatch_count,
   output int           pending_count,
   output int           ok_count,
   output int           miss_count,
   output int           full_count,
   output int           peak_waiting
);

   id_type             held_id     [2][QUEUE_DEPTH];
   logic               held_gone   [2][QUEUE_DEPTH];
   int                 head_ptr    [2];
   int                 tail_ptr    [2];
   logic [FIELD_W-1:0] ticket_next [2];
   logic [COUNT_W-1:0] waiting;
   rsp_type            expected_answers [$];
   int                 errors;
   int                 oks;
   int                 misses;
   int                 fulls;
   int                 peak;

   function automatic rsp_type predict_answer(input req_type item);
      rsp_type answer;
      int      cls;
      int      p;
      int      slot;
      id_type  id;
      answer        = '0;
      answer.status = ST_MISS;
      cls           = item.queue_class;
      id            = id_type'(item.customer_id);
      case (item.operation)
         OP_ARRIVE: begin
            if ((tail_ptr[cls] + PTR_MOD - head_ptr[cls]) % PTR_MOD >= QUEUE_DEPTH) begin
               answer.status = ST_FULL;
            end else begin
               slot                  = tail_ptr[cls] % QUEUE_DEPTH;
               held_id[cls][slot]    = id;
               held_gone[cls][slot]  = 1'b0;
               tail_ptr[cls]         = (tail_ptr[cls] + 1) % PTR_MOD;
               answer.ticket         = ticket_next[cls];
               ticket_next[cls]      = ticket_next[cls] + FIELD_W'(1);
               waiting               = waiting + COUNT_W'(1);
               answer.status         = ST_OK;
            end
         end
         OP_CALL: begin
            while (head_ptr[cls] != tail_ptr[cls] && answer.status != ST_OK) begin
               slot          = head_ptr[cls] % QUEUE_DEPTH;
               head_ptr[cls] = (head_ptr[cls] + 1) % PTR_MOD;
               if (!held_gone[cls][slot]) begin
                  answer.called_id = FIELD_W'(held_id[cls][slot]);
                  waiting          = waiting - COUNT_W'(1);
                  answer.status    = ST_OK;
               end
            end
         end
         OP_CANCEL: begin
            p = head_ptr[cls];
            while (p != tail_ptr[cls] && answer.status != ST_OK) begin
               slot = p % QUEUE_DEPTH;
               if (!held_gone[cls][slot] && held_id[cls][slot] == id) begin
                  held_gone[cls][slot] = 1'b1;
                  waiting              = waiting - COUNT_W'(1);
                  answer.status        = ST_OK;
               end
               p = (p + 1) % PTR_MOD;
            end
         end
         default: ;
      endcase
      answer.waiting_count = waiting;
      return answer;
   endfunction

   function automatic void compare_field(input string label, input logic [FIELD_W-1:0] want,
                                         input logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, label, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head_ptr    = '{0, 0};
         tail_ptr    = '{0, 0};
         ticket_next = '{'0, '0};
         waiting     = '0;
         held_id     = '{default: '0};
         held_gone   = '{default: 1'b0};
         expected_answers.delete();
         errors = 0;
         oks    = 0;
         misses = 0;
         fulls  = 0;
         peak   = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: response expected none, got %h", $time, rsp_item);
               errors++;
            end else begin
               want = expected_answers.pop_front();
               compare_field("status", FIELD_W'(want.status), FIELD_W'(rsp_item.status));
               compare_field("called_id", want.called_id, rsp_item.called_id);
               compare_field("ticket", want.ticket, rsp_item.ticket);
               compare_field("waiting_count", FIELD_W'(want.waiting_count),
                             FIELD_W'(rsp_item.waiting_count));
               case (want.status)
                  ST_OK:   oks++;
                  ST_FULL: fulls++;
                  default: misses++;
               endcase
               if (want.waiting_count > peak) begin
                  peak = want.waiting_count;
               end
            end
         end
         if (start && !busy) begin
            expected_answers = {expected_answers, predict_answer(req_item)};
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_answers.size();
      ok_count       <= oks;
      miss_count     <= misses;
      full_count     <= fulls;
      peak_waiting   <= peak;
   end

endmodule

// ===== sim/two_class_cancellable_ticket_queue_core_test.sv =====
`timescale 1ns / 100ps

module two_class_cancellable_ticket_queue_core_test;
   import tcq_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         MODE_FILL   = 0;
   localparam int         MODE_DRAIN  = 1;
   localparam int         MODE_MIX    = 2;
   localparam int         GAP_CAP     = 40;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         IDLE_PLAN [4] = '{0, 62, 0, 16};

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   int     mismatches;
   int     pending;
   int     oks;
   int     misses;
   int     fulls;
   int     peak;
   int     idle_pct   = 0;
   int     items_sent = 0;
   int     cycles     = 0;
   id_type recent_ids [2][8] = '{default: '0};

   two_class_cancellable_ticket_queue_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   ticket_queue_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatches),
      .pending_count  (pending),
      .ok_count       (oks),
      .miss_count     (misses),
      .full_count     (fulls),
      .peak_waiting   (peak)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [FIELD_W-1:0] pick_id(input logic cls);
      int r;
      r = $urandom_range(9);
      if (r < 4) begin
         return FIELD_W'(recent_ids[cls][$urandom_range(7)]);
      end
      if (r < 7) begin
         return FIELD_W'($urandom_range(15));
      end
      return FIELD_W'($urandom_range(16'hFFFF));
   endfunction

   task automatic send_item(input logic [1:0] op, input logic cls, input logic [FIELD_W-1:0] id);
      int      gap;
      req_type item;
      gap = 0;
      while (gap < GAP_CAP && $urandom_range(99) < idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      item.operation   = op;
      item.queue_class = cls;
      item.customer_id = id;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      items_sent++;
      if (op == OP_ARRIVE) begin
         recent_ids[cls][$urandom_range(7)] = id_type'(id);
      end
   endtask

   task automatic run_block(input int mode, input int length);
      logic [1:0] op;
      logic       cls;
      logic       favored;
      int         r;
      favored = 1'($urandom_range(1));
      repeat (length) begin
         r = $urandom_range(99);
         case (mode)
            MODE_FILL:  op = (r < 80) ? OP_ARRIVE : (r < 90) ? OP_CANCEL : OP_CALL;
            MODE_DRAIN: op = (r < 70) ? OP_CALL : (r < 90) ? OP_CANCEL : OP_ARRIVE;
            default:    op = (r < 5) ? OP_UNUSED : (r < 40) ? OP_ARRIVE :
                             (r < 70) ? OP_CALL : OP_CANCEL;
         endcase
         cls = (mode != MODE_MIX && $urandom_range(99) < 85) ? favored
                                                               : 1'($urandom_range(1));
         send_item(op, cls, pick_id(cls));
      end
   endtask

   initial begin
      int phase_start;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      send_item(OP_CALL,   1'b0, 16'h0000);
      send_item(OP_CANCEL, 1'b1, 16'h0000);
      send_item(OP_UNUSED, 1'b0, 16'hFFFF);
      send_item(OP_UNUSED, 1'b1, 16'h0000);
      send_item(OP_ARRIVE, 1'b0, 16'h0000);
      send_item(OP_ARRIVE, 1'b0, 16'hFFFF);
      send_item(OP_ARRIVE, 1'b0, 16'hA5A5);
      send_item(OP_ARRIVE, 1'b1, 16'hFFFF);
      send_item(OP_ARRIVE, 1'b1, 16'h5A5A);
      send_item(OP_ARRIVE, 1'b1, 16'h5A5A);
      send_item(OP_CANCEL, 1'b0, 16'hFFFF);
      send_item(OP_CANCEL, 1'b0, 16'hFFFF);
      send_item(OP_CANCEL, 1'b1, 16'h5A5A);
      send_item(OP_CANCEL, 1'b1, 16'h1234);
      send_item(OP_CALL,   1'b0, 16'hFFFF);
      send_item(OP_CALL,   1'b0, 16'h0000);
      send_item(OP_CANCEL, 1'b0, 16'hA5A5);
      send_item(OP_ARRIVE, 1'b0, 16'h8001);
      send_item(OP_CANCEL, 1'b0, 16'h8001);
      send_item(OP_CALL,   1'b0, 16'h0000);
      send_item(OP_CALL,   1'b0, 16'h0000);
      send_item(OP_CALL,   1'b1, 16'h0000);
      send_item(OP_CALL,   1'b1, 16'h0000);
      send_item(OP_CALL,   1'b1, 16'h0000);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct    = IDLE_PLAN[phase];
         phase_start = items_sent;
         if (phase == 0) begin
            for (int i = 0; i < 140; i++) begin
               send_item(OP_ARRIVE, i[0], pick_id(i[0]));
            end
         end
         while (items_sent - phase_start < 60) begin
            run_block($urandom_range(2), $urandom_range(15, 60));
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (QUEUE_DEPTH + 8) @(negedge clock);

      $display("Sent %0d items: %0d answered ok, %0d empty or not found, %0d rejected as full.",
               items_sent, oks, misses, fulls);
      $display("Waiting count peaked at %0d; %0d field mismatches.", peak, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
